// ----- rtl/bez_pkg.sv -----
// shared constants and types of the bezier segment evaluator
package bez_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int T_FRAC_BITS_DEF = 16;

   localparam logic [1:0] ORDER_LINEAR    = 2'd0;
   localparam logic [1:0] ORDER_QUADRATIC = 2'd1;
   localparam logic [1:0] ORDER_CUBIC     = 2'd2;

   typedef struct packed {
      logic       vld;
      logic [1:0] order;
   } bez_ctl_type;

endpackage

// ----- rtl/bez_level.sv -----
// one de casteljau level: difference, multiply by t, round and add, in three stages
module bez_level #(
   parameter int COORD_WIDTH = bez_pkg::COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = bez_pkg::T_FRAC_BITS_DEF,
   parameter int LANES = 1,
   parameter logic [1:0] LEVEL = bez_pkg::ORDER_LINEAR
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  bez_pkg::bez_ctl_type           in_ctl,
   input  logic [T_FRAC_BITS:0]           in_t,
   input  logic signed [COORD_WIDTH-1:0]  in_pos,
   input  logic signed [COORD_WIDTH+1:0]  in_tan,
   input  logic signed [COORD_WIDTH-1:0]  in_a [LANES],
   input  logic signed [COORD_WIDTH-1:0]  in_b [LANES],
   output bez_pkg::bez_ctl_type           out_ctl,
   output logic [T_FRAC_BITS:0]           out_t,
   output logic signed [COORD_WIDTH-1:0]  out_pos,
   output logic signed [COORD_WIDTH+1:0]  out_tan,
   output logic signed [COORD_WIDTH-1:0]  out_r [LANES]
);

   localparam int TW = T_FRAC_BITS + 1;
   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = DW + TW + 1;
   localparam int SW = COORD_WIDTH + 2;
   localparam logic signed [PW-1:0] HALF = PW'(1) <<< (T_FRAC_BITS - 1);
   localparam logic signed [SW-1:0] CMAX = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
   localparam logic signed [SW-1:0] CMIN = -(SW'(1) <<< (COORD_WIDTH - 1));

   // stage 1: differences
   bez_pkg::bez_ctl_type          s1_ctl_ff;
   logic [TW-1:0]                 s1_t_ff;
   logic signed [COORD_WIDTH-1:0] s1_pos_ff;
   logic signed [SW-1:0]          s1_tan_ff;
   logic signed [COORD_WIDTH-1:0] s1_a_ff [LANES];
   logic signed [DW-1:0]          s1_d_ff [LANES];
   logic signed [DW-1:0]          s1_d_in [LANES];
   logic signed [SW-1:0]          s1_tan_in;

   // stage 2: products
   bez_pkg::bez_ctl_type          s2_ctl_ff;
   logic [TW-1:0]                 s2_t_ff;
   logic signed [COORD_WIDTH-1:0] s2_pos_ff;
   logic signed [SW-1:0]          s2_tan_ff;
   logic signed [COORD_WIDTH-1:0] s2_a_ff [LANES];
   logic signed [PW-1:0]          s2_prod_ff [LANES];
   logic signed [PW-1:0]          s2_prod_in [LANES];

   // stage 3: rounded interpolation
   bez_pkg::bez_ctl_type          s3_ctl_ff;
   logic [TW-1:0]                 s3_t_ff;
   logic signed [COORD_WIDTH-1:0] s3_pos_ff;
   logic signed [SW-1:0]          s3_tan_ff;
   logic signed [COORD_WIDTH-1:0] s3_r_ff [LANES];
   logic signed [COORD_WIDTH-1:0] s3_r_in [LANES];
   logic signed [COORD_WIDTH-1:0] s3_pos_in;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s1_d_in[i] = DW'(in_b[i]) - DW'(in_a[i]);
      end
      // the last-level difference is the tangent
      s1_tan_in = (in_ctl.order == LEVEL) ? SW'(s1_d_in[0]) : in_tan;
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s2_prod_in[i] = PW'(s1_d_ff[i]) * PW'($signed({1'b0, s1_t_ff}));
      end
   end

   always_comb begin
      logic signed [PW-1:0] rnd;
      logic signed [SW-1:0] sum;
      rnd = '0;
      sum = '0;
      for (int i = 0; i < LANES; i++) begin
         // round to nearest, ties up
         rnd = (s2_prod_ff[i] + HALF) >>> T_FRAC_BITS;
         sum = SW'(s2_a_ff[i]) + rnd[SW-1:0];
         if (sum > CMAX) begin
            s3_r_in[i] = CMAX[COORD_WIDTH-1:0];
         end else if (sum < CMIN) begin
            s3_r_in[i] = CMIN[COORD_WIDTH-1:0];
         end else begin
            s3_r_in[i] = sum[COORD_WIDTH-1:0];
         end
      end
      s3_pos_in = (s2_ctl_ff.order == LEVEL) ? s3_r_in[0] : s2_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= in_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_t_ff    <= in_t;
         s1_pos_ff  <= in_pos;
         s1_tan_ff  <= s1_tan_in;
         s1_a_ff    <= in_a;
         s1_d_ff    <= s1_d_in;
         s2_t_ff    <= s1_t_ff;
         s2_pos_ff  <= s1_pos_ff;
         s2_tan_ff  <= s1_tan_ff;
         s2_a_ff    <= s1_a_ff;
         s2_prod_ff <= s2_prod_in;
         s3_t_ff    <= s2_t_ff;
         s3_pos_ff  <= s3_pos_in;
         s3_tan_ff  <= s2_tan_ff;
         s3_r_ff    <= s3_r_in;
      end
   end

   assign out_ctl = s3_ctl_ff;
   assign out_t   = s3_t_ff;
   assign out_pos = s3_pos_ff;
   assign out_tan = s3_tan_ff;
   assign out_r   = s3_r_ff;

endmodule

// ----- rtl/bezier_segment_evaluator.sv -----
// top level of the bezier segment evaluator
//
// Evaluates one axis of a linear, quadratic or cubic bezier segment per item.
// The req_ channel carries the four control coordinates, t and the two
// handle flags; the rsp_ channel returns the position, the last-level
// de casteljau difference (tangent) and the curve order used.
// t above one is clamped to one.
//
// The req_ transfer reaches rsp_valid through three de casteljau
// levels, each a difference stage, a multiply-by-t stage and a round-and-add
// stage. Lower orders take the same path and pick their result at their
// own level. One item can be taken every cycle while the output is not
// stalled; the multiply stage of each level sets the cycle time.
//
// Reset clears all pipeline valid bits. While rsp_valid is high and
// rsp_ready is low the whole pipeline holds and req_ready drops; bubbles
// ahead of the output keep flowing whenever the output register is empty.
module bezier_segment_evaluator #(
   parameter int COORD_WIDTH = bez_pkg::COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = bez_pkg::T_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_start_coord,
   input  logic signed [COORD_WIDTH-1:0] req_first_handle_coord,
   input  logic signed [COORD_WIDTH-1:0] req_second_handle_coord,
   input  logic signed [COORD_WIDTH-1:0] req_end_coord,
   input  logic [T_FRAC_BITS:0]          req_param_t,
   input  logic                          req_has_first_handle,
   input  logic                          req_has_second_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_position,
   output logic signed [COORD_WIDTH+1:0] rsp_tangent,
   output logic [1:0]                    rsp_curve_order
);

   localparam int TW = T_FRAC_BITS + 1;
   localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

   logic                          advance;
   bez_pkg::bez_ctl_type          in_ctl;
   logic [TW-1:0]                 t_clamped;
   logic signed [COORD_WIDTH-1:0] x1;
   logic signed [COORD_WIDTH-1:0] x2;
   logic signed [COORD_WIDTH-1:0] l1_a [3];
   logic signed [COORD_WIDTH-1:0] l1_b [3];

   bez_pkg::bez_ctl_type          l1_ctl;
   logic [TW-1:0]                 l1_t;
   logic signed [COORD_WIDTH-1:0] l1_pos;
   logic signed [COORD_WIDTH+1:0] l1_tan;
   logic signed [COORD_WIDTH-1:0] l1_r [3];
   logic signed [COORD_WIDTH-1:0] l2_a [2];
   logic signed [COORD_WIDTH-1:0] l2_b [2];

   bez_pkg::bez_ctl_type          l2_ctl;
   logic [TW-1:0]                 l2_t;
   logic signed [COORD_WIDTH-1:0] l2_pos;
   logic signed [COORD_WIDTH+1:0] l2_tan;
   logic signed [COORD_WIDTH-1:0] l2_r [2];
   logic signed [COORD_WIDTH-1:0] l3_a [1];
   logic signed [COORD_WIDTH-1:0] l3_b [1];

   bez_pkg::bez_ctl_type          l3_ctl;

   // the whole pipeline moves unless a finished result is waiting
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      t_clamped = (req_param_t > T_ONE) ? T_ONE : req_param_t;
      in_ctl.vld = req_valid;
      if (req_has_first_handle && req_has_second_handle) begin
         in_ctl.order = bez_pkg::ORDER_CUBIC;
      end else if (req_has_first_handle || req_has_second_handle) begin
         in_ctl.order = bez_pkg::ORDER_QUADRATIC;
      end else begin
         in_ctl.order = bez_pkg::ORDER_LINEAR;
      end
      // lower orders fold onto the first lanes of the cubic network
      if (req_has_first_handle) begin
         x1 = req_first_handle_coord;
      end else if (req_has_second_handle) begin
         x1 = req_second_handle_coord;
      end else begin
         x1 = req_end_coord;
      end
      x2 = (req_has_first_handle && req_has_second_handle) ? req_second_handle_coord
                                                           : req_end_coord;
      l1_a[0] = req_start_coord;
      l1_b[0] = x1;
      l1_a[1] = x1;
      l1_b[1] = x2;
      l1_a[2] = x2;
      l1_b[2] = req_end_coord;
   end

   bez_level #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS),
      .LANES       (3),
      .LEVEL       (bez_pkg::ORDER_LINEAR)
   ) u_level1 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (in_ctl),
      .in_t    (t_clamped),
      .in_pos  ('0),
      .in_tan  ('0),
      .in_a    (l1_a),
      .in_b    (l1_b),
      .out_ctl (l1_ctl),
      .out_t   (l1_t),
      .out_pos (l1_pos),
      .out_tan (l1_tan),
      .out_r   (l1_r)
   );

   always_comb begin
      l2_a[0] = l1_r[0];
      l2_b[0] = l1_r[1];
      l2_a[1] = l1_r[1];
      l2_b[1] = l1_r[2];
   end

   bez_level #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS),
      .LANES       (2),
      .LEVEL       (bez_pkg::ORDER_QUADRATIC)
   ) u_level2 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (l1_ctl),
      .in_t    (l1_t),
      .in_pos  (l1_pos),
      .in_tan  (l1_tan),
      .in_a    (l2_a),
      .in_b    (l2_b),
      .out_ctl (l2_ctl),
      .out_t   (l2_t),
      .out_pos (l2_pos),
      .out_tan (l2_tan),
      .out_r   (l2_r)
   );

   always_comb begin
      l3_a[0] = l2_r[0];
      l3_b[0] = l2_r[1];
   end

   // last level registers double as the output register
   bez_level #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS),
      .LANES       (1),
      .LEVEL       (bez_pkg::ORDER_CUBIC)
   ) u_level3 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (l2_ctl),
      .in_t    (l2_t),
      .in_pos  (l2_pos),
      .in_tan  (l2_tan),
      .in_a    (l3_a),
      .in_b    (l3_b),
      .out_ctl (l3_ctl),
      .out_t   (),
      .out_pos (rsp_position),
      .out_tan (rsp_tangent),
      .out_r   ()
   );

   assign rsp_valid       = l3_ctl.vld;
   assign rsp_curve_order = l3_ctl.order;

endmodule

// ----- test/tb_bezier_segment_evaluator.sv -----
// testbench for the bezier segment evaluator: directed and random segments against a predictor
`timescale 1ns / 1ps

module tb_bezier_segment_evaluator;

   localparam int COORD_W     = bez_pkg::COORD_WIDTH_DEF;
   localparam int T_FRAC      = bez_pkg::T_FRAC_BITS_DEF;
   localparam longint T_ONE   = longint'(1) << T_FRAC;
   localparam longint T_HALF  = T_ONE >>> 1;
   localparam longint POS_MAX = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint POS_MIN = -(longint'(1) << (COORD_W - 1));
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 1800;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct {
      logic signed [COORD_W-1:0] position;
      logic signed [COORD_W+1:0] tangent;
      logic [1:0]                curve_order;
   } segment_eval_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   coord_type         req_start_coord = '0;
   coord_type         req_first_handle_coord = '0;
   coord_type         req_second_handle_coord = '0;
   coord_type         req_end_coord = '0;
   logic [T_FRAC:0]   req_param_t = '0;
   logic              req_has_first_handle = 1'b0;
   logic              req_has_second_handle = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   coord_type         rsp_position;
   logic signed [COORD_W+1:0] rsp_tangent;
   logic [1:0]        rsp_curve_order;

   segment_eval_type pending_evals[$];
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;

   bezier_segment_evaluator dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_start_coord        (req_start_coord),
      .req_first_handle_coord (req_first_handle_coord),
      .req_second_handle_coord(req_second_handle_coord),
      .req_end_coord          (req_end_coord),
      .req_param_t            (req_param_t),
      .req_has_first_handle   (req_has_first_handle),
      .req_has_second_handle  (req_has_second_handle),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_position           (rsp_position),
      .rsp_tangent            (rsp_tangent),
      .rsp_curve_order        (rsp_curve_order)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // a + round-half-up((b - a) * t / one); products stay well inside 64 bits
   function automatic longint lerp_round(longint a, longint b, longint t);
      return a + (((b - a) * t + T_HALF) >>> T_FRAC);
   endfunction

   function automatic segment_eval_type eval_segment(coord_type p0, coord_type h1,
                                                     coord_type h2, coord_type p3,
                                                     logic [T_FRAC:0] t_raw,
                                                     logic f1, logic f2);
      segment_eval_type res;
      longint t, a, b, c, ab, bc, pos, tan;
      longint h;
      t = (longint'(t_raw) > T_ONE) ? T_ONE : longint'(t_raw);
      if (f1 && f2) begin
         a   = lerp_round(p0, h1, t);
         b   = lerp_round(h1, h2, t);
         c   = lerp_round(h2, p3, t);
         ab  = lerp_round(a, b, t);
         bc  = lerp_round(b, c, t);
         pos = lerp_round(ab, bc, t);
         tan = bc - ab;
         res.curve_order = bez_pkg::ORDER_CUBIC;
      end else if (f1 || f2) begin
         h   = f1 ? longint'(h1) : longint'(h2);
         a   = lerp_round(p0, h, t);
         b   = lerp_round(h, p3, t);
         pos = lerp_round(a, b, t);
         tan = b - a;
         res.curve_order = bez_pkg::ORDER_QUADRATIC;
      end else begin
         pos = lerp_round(p0, p3, t);
         tan = longint'(p3) - longint'(p0);
         res.curve_order = bez_pkg::ORDER_LINEAR;
      end
      if (pos > POS_MAX) pos = POS_MAX;
      if (pos < POS_MIN) pos = POS_MIN;
      res.position = pos[COORD_W-1:0];
      res.tangent  = tan[COORD_W+1:0];
      return res;
   endfunction

   function automatic coord_type rand_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0: return coord_type'(POS_MAX);
         1: return coord_type'(POS_MIN);
         2, 3: return coord_type'({{15{r[16]}}, r[16:0]});
         default: return coord_type'(r);
      endcase
   endfunction

   function automatic logic [T_FRAC:0] rand_param();
      case ($urandom_range(9))
         0: return '0;
         1: return T_FRAC'(0) | (T_FRAC+1)'(T_ONE);
         2: return (T_FRAC+1)'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
         default: return (T_FRAC+1)'($urandom_range(0, T_ONE));
      endcase
   endfunction

   // receiver side: random stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // check results against the oldest expectation, then record new transfers
   always @(posedge clock) begin
      segment_eval_type exp_eval;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("FAIL");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_evals.size() == 0) begin
            $display("%0t unexpected result: position %0d tangent %0d order %0d",
                     $time, rsp_position, rsp_tangent, rsp_curve_order);
            error_count++;
         end else begin
            exp_eval = pending_evals.pop_front();
            if (rsp_position !== exp_eval.position) begin
               $display("%0t position mismatch: expected %0d actual %0d",
                        $time, exp_eval.position, rsp_position);
               error_count++;
            end
            if (rsp_tangent !== exp_eval.tangent) begin
               $display("%0t tangent mismatch: expected %0d actual %0d",
                        $time, exp_eval.tangent, rsp_tangent);
               error_count++;
            end
            if (rsp_curve_order !== exp_eval.curve_order) begin
               $display("%0t curve_order mismatch: expected %0d actual %0d",
                        $time, exp_eval.curve_order, rsp_curve_order);
               error_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready)
         pending_evals.push_back(eval_segment(req_start_coord, req_first_handle_coord,
                                              req_second_handle_coord, req_end_coord,
                                              req_param_t, req_has_first_handle,
                                              req_has_second_handle));
   end

   // drive one segment and hold it until the transfer
   task automatic send_segment(coord_type p0, coord_type h1, coord_type h2, coord_type p3,
                               logic [T_FRAC:0] t, logic f1, logic f2);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid               <= 1'b1;
      req_start_coord         <= p0;
      req_first_handle_coord  <= h1;
      req_second_handle_coord <= h2;
      req_end_coord           <= p3;
      req_param_t             <= t;
      req_has_first_handle    <= f1;
      req_has_second_handle   <= f2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic test_endpoints();
      for (int flags = 0; flags < 4; flags++) begin
         send_segment(32'sh0001_8000, -32'sh0003_0000, 32'sh0007_4000, -32'sh0002_0001,
                      '0, flags[0], flags[1]);
         send_segment(32'sh0001_8000, -32'sh0003_0000, 32'sh0007_4000, -32'sh0002_0001,
                      (T_FRAC+1)'(T_ONE), flags[0], flags[1]);
      end
   endtask

   task automatic test_param_clamp();
      send_segment(32'sh0010_0000, 32'sh0020_0000, -32'sh0030_0000, 32'sh0005_0000,
                   (T_FRAC+1)'(T_ONE + 1), 1'b1, 1'b1);
      send_segment(32'sh0010_0000, 32'sh0020_0000, -32'sh0030_0000, 32'sh0005_0000,
                   '1, 1'b1, 1'b1);
      send_segment(-32'sh0000_0001, 32'sh0, 32'sh0, 32'sh7fff_ffff, '1, 1'b0, 1'b0);
   endtask

   task automatic test_coord_extremes();
      coord_type cmax, cmin;
      cmax = coord_type'(POS_MAX);
      cmin = coord_type'(POS_MIN);
      send_segment(cmax, cmax, cmax, cmax, (T_FRAC+1)'(T_HALF), 1'b1, 1'b1);
      send_segment(cmin, cmin, cmin, cmin, (T_FRAC+1)'(T_HALF), 1'b1, 1'b1);
      send_segment(cmin, cmax, cmin, cmax, (T_FRAC+1)'(T_HALF), 1'b1, 1'b1);
      send_segment(cmax, cmin, cmax, cmin, 17'd1, 1'b1, 1'b1);
      send_segment(cmin, cmax, cmin, cmax, (T_FRAC+1)'(T_ONE - 1), 1'b1, 1'b0);
      send_segment(cmax, cmin, cmax, cmin, (T_FRAC+1)'(T_ONE - 1), 1'b0, 1'b1);
      send_segment(cmin, '0, '0, cmax, 17'd12345, 1'b0, 1'b0);
   endtask

   // half-lsb ties round toward plus infinity in both directions
   task automatic test_tie_rounding();
      send_segment('0, '0, '0, 32'sd1, (T_FRAC+1)'(T_HALF), 1'b0, 1'b0);
      send_segment('0, '0, '0, -32'sd1, (T_FRAC+1)'(T_HALF), 1'b0, 1'b0);
      send_segment('0, 32'sd1, '0, 32'sd3, (T_FRAC+1)'(T_HALF), 1'b1, 1'b0);
   endtask

   task automatic test_random_segments(int unsigned count, int unsigned idle_pct,
                                       int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count)
         send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_param(), 1'($urandom), 1'($urandom));
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_endpoints();
      test_param_clamp();
      test_coord_extremes();
      test_tie_rounding();
      test_random_segments(RANDOM_ITEMS / 4, 0, 0);
      test_random_segments(RANDOM_ITEMS / 4, 84, 0);
      test_random_segments(RANDOM_ITEMS / 4, 0, 84);
      test_random_segments(RANDOM_ITEMS / 4, 16, 16);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_evals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_evals.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
